[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/snre_pkg.sv]
// ----------------------------------------------------------------------------
// snre_pkg
// Types and constants of the sparse nonzero run encoder.
// ----------------------------------------------------------------------------
package snre_pkg;

	localparam int RUN_WORDS = 32;                   // run buffer depth in words
	localparam int AW        = $clog2(RUN_WORDS);    // buffer address width
	localparam int KW        = $clog2(RUN_WORDS + 1); // word count width

	localparam logic [33:0] HDR_SIZE  = 34'd8;
	localparam logic [33:0] WORD_SIZE = 34'd8;
	localparam logic [33:0] POS_LIMIT = 34'h0_FFFF_FFFF;

	localparam logic REG_GAP_WORDS = 1'b0;
	localparam logic REG_CAPACITY  = 1'b1;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} item_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_TOO_LARGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POS,
		S_GAP,
		S_WORD,
		S_START,
		S_LAST,
		S_FHDR,
		S_FPAY,
		S_TAIL,
		S_TPAY,
		S_STAT,
		S_FAIL
	} state_t;

endpackage

[hw/rtl/sparse_nonzero_run_encoder.sv]
// ----------------------------------------------------------------------------
// sparse_nonzero_run_encoder
// Packs a memory image, one 64-bit word at a time, into records of nonzero
// runs. Runs are joined across short zero gaps (the gap register), split at 32
// words, and each closed run is sent as a header (byte offset, byte length)
// followed by its words; a nonzero partial tail becomes its own record, and
// every image ends with one status word (ok, overflow, too large) carrying the
// bytes used. After a failure the rest of the image is swallowed up to its
// last word. The open run lives in a 32-entry RAM with a registered
// read; a sequencer writes each word in and reads the run back when it closes.
// Flow: one input word at a time; a plain full word passes the POS, GAP and
// WORD states (and START when it opens a run), a discarded word is accepted
// every cycle. Closing a run sends the header, then the buffered words (RAM
// read streamed one word per cycle); the end of an image passes the last word,
// tail check and status steps plus a tail record, all stretched by any output
// stall. The output word sits in a register, so a finished result may wait on
// out_ready while the next input word is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_nonzero_run_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] word_data,
	input  logic [3:0]  valid_bytes,
	input  logic        last_item,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  item_kind,
	output logic [31:0] run_offset,
	output logic [31:0] run_length,
	output logic [63:0] payload_word,
	output logic [3:0]  payload_bytes,
	output logic [1:0]  result_status,
	output logic [31:0] total_used,
	output logic        last_of_run
);

	import snre_pkg::*;

	// configuration
	logic [15:0] gap_q;
	logic [31:0] cap_q;

	// sequencer and encoder state
	state_t        state_q, state_d;
	state_t        ret_q, ret_d;         // where a run flush returns to
	logic          in_run_q, in_run_d;
	logic [28:0]   run_start_q, run_start_d;
	logic [15:0]   wsn_q, wsn_d;         // zero words since last nonzero word
	logic [KW-1:0] kept_q, kept_d;       // words held in the run buffer
	logic [29:0]   pos_q, pos_d;         // word position in the image
	logic [32:0]   written_q, written_d; // bytes sent to the output area
	logic          discard_q, discard_d;
	logic [KW-1:0] flen_q, flen_d;       // words of the run being flushed
	logic [KW-1:0] fidx_q, fidx_d;
	status_t       fcode_q, fcode_d;

	// latched input word
	logic [63:0] word_q, word_d;
	logic [2:0]  vb_q, vb_d;             // tail byte count
	logic        full_q, full_d;
	logic        last_q, last_d;         // last, forced on a partial word

	// output register
	logic        out_valid_q;
	item_kind_t  kind_q;
	logic [31:0] off_q, len_q, used_q;
	logic [63:0] pword_q;
	logic [3:0]  pbytes_q;
	status_t     status_q;
	logic        lor_q;

	// emit request from the sequencer
	logic        emit;
	item_kind_t  e_kind;
	logic [31:0] e_off, e_len, e_used;
	logic [63:0] e_word;
	logic [3:0]  e_bytes;
	status_t     e_stat;
	logic        e_lor;

	// run buffer port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;

	logic          slot_free;
	logic          end_img;
	logic [33:0]   pos_end;
	logic [33:0]   run_sum;
	logic [33:0]   tail_sum;
	logic [16:0]   slot_sum;
	logic [16:0]   need;
	logic [KW-1:0] fidx_next;
	logic [63:0]   tail_word;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);

	// tail bytes beyond the valid count read as zero
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			tail_word[8*b +: 8] = (3'(b) < vb_q) ? word_q[8*b +: 8] : 8'h00;
		end
	end

	assign pos_end   = {1'b0, pos_q, 3'b000} + (full_q ? WORD_SIZE : 34'(vb_q));
	assign run_sum   = {1'b0, written_q} + HDR_SIZE + 34'({kept_q, 3'b000});
	assign tail_sum  = {1'b0, written_q} + HDR_SIZE + 34'(vb_q);
	assign slot_sum  = 17'(kept_q) + 17'(wsn_q);
	assign need      = slot_sum + 17'd1;
	assign fidx_next = fidx_q + 1'b1;

	snre_ram #(
		.WIDTH(64),
		.DEPTH(RUN_WORDS)
	) u_run_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state, buffer access and result selection
	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		in_run_d    = in_run_q;
		run_start_d = run_start_q;
		wsn_d       = wsn_q;
		kept_d      = kept_q;
		pos_d       = pos_q;
		written_d   = written_q;
		discard_d   = discard_q;
		flen_d      = flen_q;
		fidx_d      = fidx_q;
		fcode_d     = fcode_q;
		word_d      = word_q;
		vb_d        = vb_q;
		full_d      = full_q;
		last_d      = last_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = '0;
		emit        = 1'b0;
		e_kind      = KIND_HEADER;
		e_off       = '0;
		e_len       = '0;
		e_word      = '0;
		e_bytes     = '0;
		e_stat      = ST_OK;
		e_used      = '0;
		e_lor       = 1'b0;
		end_img     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					word_d = word_data;
					vb_d   = valid_bytes[2:0];
					full_d = valid_bytes[3];
					last_d = last_item || !valid_bytes[3];
					if (discard_q) begin
						// swallow words until the image ends
						end_img = last_item || !valid_bytes[3];
					end else begin
						state_d = S_POS;
					end
				end
			end
			S_POS: begin
				if (pos_end > POS_LIMIT) begin
					fcode_d = ST_TOO_LARGE;
					state_d = S_FAIL;
				end else begin
					state_d = full_q ? S_GAP : S_LAST;
				end
			end
			S_GAP: begin
				if (in_run_q && wsn_q >= gap_q) begin
					ret_d   = S_WORD;
					state_d = S_FHDR;
				end else begin
					state_d = S_WORD;
				end
			end
			S_WORD: begin
				if (word_q != 64'd0) begin
					if (!in_run_q) begin
						state_d = S_START;
					end else if (need > 17'(RUN_WORDS)) begin
						// run would not fit: send it, then restart here
						ret_d   = S_START;
						state_d = S_FHDR;
					end else begin
						// gap zeros already sit in the buffer
						ram_we    = 1'b1;
						ram_waddr = slot_sum[AW-1:0];
						ram_wdata = word_q;
						kept_d    = need[KW-1:0];
						wsn_d     = '0;
						pos_d     = pos_q + 1'b1;
						state_d   = last_q ? S_LAST : S_IDLE;
					end
				end else begin
					if (in_run_q && wsn_q != 16'hFFFF) begin
						if (slot_sum < 17'(RUN_WORDS)) begin
							ram_we    = 1'b1;
							ram_waddr = slot_sum[AW-1:0];
						end
						wsn_d = wsn_q + 1'b1;
					end
					pos_d   = pos_q + 1'b1;
					state_d = last_q ? S_LAST : S_IDLE;
				end
			end
			S_START: begin
				ram_we      = 1'b1;
				ram_waddr   = '0;
				ram_wdata   = word_q;
				kept_d      = KW'(1);
				wsn_d       = '0;
				in_run_d    = 1'b1;
				run_start_d = pos_q[28:0];
				pos_d       = pos_q + 1'b1;
				state_d     = last_q ? S_LAST : S_IDLE;
			end
			S_LAST: begin
				if (in_run_q) begin
					ret_d   = S_TAIL;
					state_d = S_FHDR;
				end else begin
					state_d = S_TAIL;
				end
			end
			S_FHDR: begin
				if (run_sum > {2'b00, cap_q}) begin
					fcode_d = ST_OVERFLOW;
					state_d = S_FAIL;
				end else if (slot_free) begin
					emit      = 1'b1;
					e_kind    = KIND_HEADER;
					e_off     = {run_start_q, 3'b000};
					e_len     = 32'({kept_q, 3'b000});
					written_d = run_sum[32:0];
					in_run_d  = 1'b0;
					wsn_d     = '0;
					flen_d    = kept_q;
					kept_d    = '0;
					fidx_d    = '0;
					ram_re    = 1'b1;
					ram_raddr = '0;
					state_d   = S_FPAY;
				end
			end
			S_FPAY: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = KIND_PAYLOAD;
					e_word  = ram_rdata;
					e_bytes = 4'd8;
					// a flush ends the step unless the image end follows
					e_lor   = (fidx_next == flen_q) && !last_q;
					if (fidx_next == flen_q) begin
						state_d = ret_q;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = fidx_next[AW-1:0];
						fidx_d    = fidx_next;
					end
				end
			end
			S_TAIL: begin
				if (!full_q && vb_q != 3'd0 && tail_word != 64'd0) begin
					if (tail_sum > {2'b00, cap_q}) begin
						fcode_d = ST_OVERFLOW;
						state_d = S_FAIL;
					end else if (slot_free) begin
						emit      = 1'b1;
						e_kind    = KIND_HEADER;
						e_off     = {pos_q[28:0], 3'b000};
						e_len     = 32'(vb_q);
						written_d = tail_sum[32:0];
						state_d   = S_TPAY;
					end
				end else begin
					state_d = S_STAT;
				end
			end
			S_TPAY: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = KIND_PAYLOAD;
					e_word  = tail_word;
					e_bytes = 4'(vb_q);
					state_d = S_STAT;
				end
			end
			S_STAT: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = KIND_STATUS;
					e_stat  = ST_OK;
					e_used  = written_q[31:0];
					e_lor   = 1'b1;
					end_img = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FAIL: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = KIND_STATUS;
					e_stat  = fcode_q;
					e_used  = written_q[31:0];
					e_lor   = 1'b1;
					end_img = last_q;
					discard_d = !last_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (end_img) begin
			in_run_d    = 1'b0;
			run_start_d = '0;
			wsn_d       = '0;
			kept_d      = '0;
			pos_d       = '0;
			written_d   = '0;
			discard_d   = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			in_run_q    <= 1'b0;
			run_start_q <= '0;
			wsn_q       <= '0;
			kept_q      <= '0;
			pos_q       <= '0;
			written_q   <= '0;
			discard_q   <= 1'b0;
			gap_q       <= '0;
			cap_q       <= 32'hFFFF_FFFF;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			in_run_q    <= in_run_d;
			run_start_q <= run_start_d;
			wsn_q       <= wsn_d;
			kept_q      <= kept_d;
			pos_q       <= pos_d;
			written_q   <= written_d;
			discard_q   <= discard_d;
			if (cfg_wr_en) begin
				if (cfg_index == REG_GAP_WORDS) begin
					gap_q <= cfg_data[15:0];
				end else if (cfg_index == REG_CAPACITY) begin
					cap_q <= cfg_data;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		flen_q  <= flen_d;
		fidx_q  <= fidx_d;
		fcode_q <= fcode_d;
		word_q  <= word_d;
		vb_q    <= vb_d;
		full_q  <= full_d;
		last_q  <= last_d;
		if (emit) begin
			kind_q   <= e_kind;
			off_q    <= e_off;
			len_q    <= e_len;
			pword_q  <= e_word;
			pbytes_q <= e_bytes;
			status_q <= e_stat;
			used_q   <= e_used;
			lor_q    <= e_lor;
		end
	end

	assign out_valid     = out_valid_q;
	assign item_kind     = kind_q;
	assign run_offset    = off_q;
	assign run_length    = len_q;
	assign payload_word  = pword_q;
	assign payload_bytes = pbytes_q;
	assign result_status = status_q;
	assign total_used    = used_q;
	assign last_of_run   = lor_q;

	`ASSERT_RST(a_kept_bound, kept_q <= KW'(RUN_WORDS), "run buffer count past depth")
	`ASSERT_RST(a_run_nonempty, in_run_q |-> kept_q != '0, "open run with no buffered word")
	`ASSERT_ALWAYS(a_ram_no_overlap, !(ram_we && ram_re), "run buffer read and written at once")
	`ASSERT_RST(a_status_ends_step, out_valid_q && kind_q == KIND_STATUS |-> lor_q, "status word not marked as final")
	`ASSERT_RST(a_emit_slot, emit |-> slot_free, "result overwrites a waiting word")

endmodule

[hw/rtl/snre_ram.sv]
// ----------------------------------------------------------------------------
// snre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module snre_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Feeds memory images to sparse_nonzero_run_encoder, word by word, with
// random stalls on both handshakes, and checks every result word in order
// against a built-in model of the run encoding.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import snre_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 12;

	// one result word as the block presents it
	typedef struct packed {
		item_kind_t  kind;
		logic [31:0] offset;
		logic [31:0] span;
		logic [63:0] data;
		logic [3:0]  nbytes;
		status_t     status;
		logic [31:0] used;
		logic        tail_flag;
	} record_word_t;

	// one input word waiting to be sent
	typedef struct {
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        final_word;
	} image_word_t;

	// Model of the encoder plus the queue of result words still owed.
	class record_scoreboard;
		record_word_t    expected_words[$];
		int              errors;
		logic [15:0]     gap_limit;
		logic [31:0]     capacity;
		logic [63:0]     held_words[RUN_WORDS];
		bit              run_open;
		logic [28:0]     run_first_word;
		int unsigned     zero_streak;
		int unsigned     held_count;
		logic [29:0]     word_index;
		longint unsigned out_bytes;
		bit              swallowing;

		function new();
			gap_limit = '0;
			capacity  = '1;
			errors    = 0;
			clear_image();
		endfunction

		function void clear_image();
			run_open       = 1'b0;
			run_first_word = '0;
			zero_streak    = 0;
			held_count     = 0;
			word_index     = '0;
			out_bytes      = 0;
			swallowing     = 1'b0;
		endfunction

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == REG_GAP_WORDS)
				gap_limit = value[15:0];
			else
				capacity = value;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void push(item_kind_t k, logic [31:0] off, logic [31:0] span,
				logic [63:0] d, logic [3:0] nb, status_t st, logic [31:0] used);
			record_word_t r;
			r.kind      = k;
			r.offset    = off;
			r.span      = span;
			r.data      = d;
			r.nbytes    = nb;
			r.status    = st;
			r.used      = used;
			r.tail_flag = 1'b0;
			expected_words.push_back(r);
		endfunction

		// header plus payload must fit in what is left of the output area
		function bit fits(longint unsigned len);
			return out_bytes + 64'd8 + len <= 64'(capacity);
		endfunction

		function bit send_run();
			longint unsigned len;
			int unsigned k;
			len = held_count * 8;
			if (!fits(len))
				return 1'b0;
			push(KIND_HEADER, {run_first_word, 3'b000}, len[31:0], '0, '0, ST_OK, '0);
			for (k = 0; k < held_count; k++)
				push(KIND_PAYLOAD, '0, '0, held_words[k], 4'd8, ST_OK, '0);
			out_bytes   += 8 + len;
			run_open    = 1'b0;
			held_count  = 0;
			zero_streak = 0;
			return 1'b1;
		endfunction

		function void start_run(logic [63:0] d);
			run_first_word = word_index[28:0];
			held_words[0]  = d;
			held_count     = 1;
			zero_streak    = 0;
			run_open       = 1'b1;
		endfunction

		function void report_failure(status_t st, bit ends);
			push(KIND_STATUS, '0, '0, '0, '0, st, out_bytes[31:0]);
			if (ends)
				clear_image();
			else
				swallowing = 1'b1;
		endfunction

		function void encode(logic [63:0] d, logic [3:0] nb, bit fin);
			bit whole;
			int unsigned take;
			logic [63:0] tail;
			whole = nb >= 4'd8;
			take  = whole ? 8 : nb;
			// after a failure everything up to the image end is dropped
			if (swallowing) begin
				if (fin || !whole)
					clear_image();
				return;
			end
			// a partial word always closes the image
			if (!whole)
				fin = 1'b1;
			if (64'(word_index) * 8 + take > 64'hFFFF_FFFF) begin
				report_failure(ST_TOO_LARGE, fin);
				return;
			end
			if (whole) begin
				if (run_open && zero_streak >= gap_limit) begin
					if (!send_run()) begin
						report_failure(ST_OVERFLOW, fin);
						return;
					end
				end
				if (d != '0) begin
					if (!run_open)
						start_run(d);
					else if (held_count + zero_streak + 1 > RUN_WORDS) begin
						// buffer full: close the run, this word opens the next
						if (!send_run()) begin
							report_failure(ST_OVERFLOW, fin);
							return;
						end
						start_run(d);
					end else begin
						repeat (zero_streak) begin
							held_words[held_count] = '0;
							held_count++;
						end
						held_words[held_count] = d;
						held_count++;
						zero_streak = 0;
					end
				end else if (run_open && zero_streak < 16'hFFFF)
					zero_streak++;
				word_index++;
			end
			if (fin) begin
				if (run_open && !send_run()) begin
					report_failure(ST_OVERFLOW, 1'b1);
					return;
				end
				if (!whole && nb != 0) begin
					tail = d & ((64'd1 << (8 * nb)) - 64'd1);
					if (tail != '0) begin
						if (!fits(nb)) begin
							report_failure(ST_OVERFLOW, 1'b1);
							return;
						end
						push(KIND_HEADER, {word_index[28:0], 3'b000}, {28'd0, nb}, '0, '0,
							ST_OK, '0);
						push(KIND_PAYLOAD, '0, '0, tail, nb, ST_OK, '0);
						out_bytes += 8 + nb;
					end
				end
				push(KIND_STATUS, '0, '0, '0, '0, ST_OK, out_bytes[31:0]);
				clear_image();
			end
		endfunction

		// predict the result words of one accepted input word
		function void take_word(logic [63:0] d, logic [3:0] nb, bit fin);
			int first;
			record_word_t r;
			first = expected_words.size();
			encode(d, nb, fin);
			if (expected_words.size() > first) begin
				r = expected_words.pop_back();
				r.tail_flag = 1'b1;
				expected_words.push_back(r);
			end
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] seen);
			if (seen !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, seen);
			end
		endfunction

		function void check_record(record_word_t got);
			record_word_t want;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: result word kind %0d arrived with nothing expected",
					$time, got.kind);
				return;
			end
			want = expected_words.pop_front();
			compare("item_kind", want.kind, got.kind);
			compare("run_offset", want.offset, got.offset);
			compare("run_length", want.span, got.span);
			compare("payload_word", want.data, got.data);
			compare("payload_bytes", want.nbytes, got.nbytes);
			compare("result_status", want.status, got.status);
			compare("total_used", want.used, got.used);
			compare("last_of_run", want.tail_flag, got.tail_flag);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] word_data;
	logic [3:0]  valid_bytes;
	logic        last_item;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  item_kind;
	logic [31:0] run_offset;
	logic [31:0] run_length;
	logic [63:0] payload_word;
	logic [3:0]  payload_bytes;
	logic [1:0]  result_status;
	logic [31:0] total_used;
	logic        last_of_run;

	bit               idling = 1'b1;   // random gaps and stalls allowed
	int unsigned      cycles = 0;
	logic [15:0]      cur_gap;         // gap setting the image builder aims at
	record_scoreboard sb;
	image_word_t      backlog[$];      // words of queued images waiting to go out

	sparse_nonzero_run_encoder uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d result words still expected", $time, sb.pending());
			$display("[sparse_nonzero_run_encoder] ERROR");
			$finish;
		end
	end

	// Result side: check each word taken, then decide ready for the next edge.
	// Stalls come in bursts and start only while idling is set.
	initial begin
		int unsigned hold;
		record_word_t seen;
		hold      = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				seen.kind      = item_kind_t'(item_kind);
				seen.offset    = run_offset;
				seen.span      = run_length;
				seen.data      = payload_word;
				seen.nbytes    = payload_bytes;
				seen.status    = status_t'(result_status);
				seen.used      = total_used;
				seen.tail_flag = last_of_run;
				sb.check_record(seen);
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// Send one input word; returns at the edge that accepts it. While idling,
	// a random gap may come first.
	task automatic put_word(logic [63:0] d, logic [3:0] nb, logic fin);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		word_data   <= d;
		valid_bytes <= nb;
		last_item   <= fin;
		do @(posedge clk); while (!in_ready);
		sb.take_word(d, nb, fin);
	endtask

	// Wait until every owed result has arrived, then give the block time to
	// finish words that produce nothing.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers, back to back, only while the block is idle
	task automatic write_regs(logic [15:0] gap, logic [31:0] cap);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_GAP_WORDS;
		cfg_data  <= {16'd0, gap};
		@(posedge clk);
		sb.write_reg(REG_GAP_WORDS, {16'd0, gap});
		cfg_index <= REG_CAPACITY;
		cfg_data  <= cap;
		@(posedge clk);
		sb.write_reg(REG_CAPACITY, cap);
		cfg_wr_en <= 1'b0;
		cur_gap = gap;
	endtask

	function automatic logic [63:0] pick_nonzero();
		logic [63:0] d;
		case ($urandom_range(0, 4))
			0: d = {$urandom, $urandom};
			1: d = 64'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7));
			2: d = '1;
			3: d = 64'd1 << $urandom_range(0, 63);
			default: d = {32'd0, $urandom};
		endcase
		if (d == '0)
			d = 64'd1;
		return d;
	endfunction

	// full word: mostly 8, sometimes an oversized count that still means 8
	function automatic logic [3:0] pick_full();
		return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
	endfunction

	function automatic void push_word(logic [63:0] d, logic [3:0] nb, logic fin);
		image_word_t w;
		w.data       = d;
		w.nbytes     = nb;
		w.final_word = fin;
		backlog.push_back(w);
	endfunction

	// One image: a random mix of zero stretches and nonzero runs, then an ending.
	// Zero stretches often sit right at the joining limit; now and then a run
	// is long enough to split, and a few images are cut by a stray partial word.
	function automatic void queue_image();
		image_word_t w;
		int unsigned segs, len;
		bit long_done, broken;
		segs      = $urandom_range(1, 5);
		long_done = 1'b0;
		broken    = ($urandom_range(0, 9) == 0);
		for (int s = 0; s < segs; s++) begin
			if ($urandom_range(0, 1) == 0) begin
				len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
				if (cur_gap < 8 && $urandom_range(0, 2) == 0)
					len = cur_gap + $urandom_range(0, 1);
				if (len == 0)
					len = 1;
				repeat (len) push_word('0, pick_full(), 1'b0);
			end else begin
				len = (!long_done && $urandom_range(0, 9) == 0) ?
					$urandom_range(33, 40) : $urandom_range(1, 6);
				if (len > RUN_WORDS)
					long_done = 1'b1;
				repeat (len) push_word(pick_nonzero(), pick_full(), 1'b0);
			end
			if (broken && s == 0)
				push_word({$urandom, $urandom}, 4'($urandom_range(1, 7)), 1'b0);
		end
		case ($urandom_range(0, 8))
			0, 1, 2, 3: begin
				w = backlog.pop_back();
				w.final_word = 1'b1;
				backlog.push_back(w);
			end
			4, 5, 6: push_word({$urandom, $urandom}, 4'($urandom_range(1, 7)), 1'b1);
			7: push_word({$urandom, $urandom}, 4'd0, 1'b1);
			default: push_word({$urandom, $urandom}, 4'($urandom_range(1, 7)), 1'b0);
		endcase
	endfunction

	initial begin
		int unsigned sent;
		sb          = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = REG_GAP_WORDS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		word_data   = '0;
		valid_bytes = 4'd8;
		last_item   = 1'b0;
		cur_gap     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed words, registers still at reset values (no joining, no limit).
		// all-ones word, zero, oversized count, tiny word, 7-byte tail
		put_word('1, 4'd8, 1'b0);
		put_word('0, 4'd8, 1'b0);
		put_word(64'h8000_0000_0000_0001, 4'd15, 1'b0);
		put_word(64'h1, 4'd8, 1'b0);
		put_word('1, 4'd7, 1'b1);
		// all-zero image: status only
		put_word('0, 4'd8, 1'b1);
		// one-byte tail not marked last still ends the image
		put_word(64'h0000_0000_0000_00A5, 4'd1, 1'b0);
		// empty tail
		put_word(64'h0123_4567_89AB_CDEF, 4'd0, 1'b1);
		// tail whose nonzero bytes all lie past the valid ones
		put_word(64'hFF00_0000_0000_0000, 4'd3, 1'b1);
		settle();

		// Joining across one zero, then an overflow on the final flush.
		write_regs(16'd2, 32'd40);
		put_word(64'h1, 4'd8, 1'b0);
		put_word('0, 4'd8, 1'b0);
		put_word(64'h2, 4'd8, 1'b0);
		put_word('0, 4'd8, 1'b0);
		put_word('0, 4'd8, 1'b0);
		put_word(64'h3, 4'd8, 1'b1);
		// Overflow in mid image: the rest up to the last word is dropped.
		put_word(64'h7, 4'd8, 1'b0);
		put_word(64'h8, 4'd8, 1'b0);
		put_word(64'h9, 4'd8, 1'b0);
		put_word(64'hA, 4'd8, 1'b0);
		put_word(64'hB, 4'd8, 1'b0);
		put_word('0, 4'd8, 1'b0);
		put_word('0, 4'd8, 1'b0);
		put_word(64'h5, 4'd8, 1'b0);
		put_word(64'h6, 4'd8, 1'b1);
		settle();

		// Random images across several settings. Phases may end mid image, so
		// a setting can change under an open run. The last phase runs with
		// no idling and drains every queued image.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: write_regs(16'd1, '1);
				1: write_regs(16'd3, 32'd600);
				2: write_regs(16'hFFFF, '1);
				3: write_regs(16'd0, 32'd0);
				4: write_regs(16'd2, 32'd120);
				5: write_regs(16'($urandom_range(0, 6)), 32'($urandom_range(64, 2000)));
				default: begin
					idling = 1'b0;
					write_regs(16'd2, '1);
					queue_image();
				end
			endcase
			sent = 0;
			while (p < 6 ? sent < 10 : backlog.size() != 0) begin
				if (backlog.size() == 0)
					queue_image();
				put_word(backlog[0].data, backlog[0].nbytes, backlog[0].final_word);
				void'(backlog.pop_front());
				sent++;
			end
			settle();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[sparse_nonzero_run_encoder] OK");
		else
			$display("[sparse_nonzero_run_encoder] ERROR");
		$finish;
	end

endmodule

[sparse_nonzero_run_encoder.f]
+incdir+hw/rtl
hw/rtl/snre_pkg.sv
hw/rtl/snre_ram.sv
hw/rtl/sparse_nonzero_run_encoder.sv
tb/sv/testbench.sv
